[rtl/fdv_pkg.sv]
// package of tables, types and bit-selection functions for the feistel cipher
package fdv_pkg;

  localparam int unsigned ROUND_COUNT = 16;

  typedef logic [6:0] pos_t;
  typedef logic [4:0] shift_t;

  localparam pos_t IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam pos_t FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam pos_t E_TAB [48] = '{
    7'd32, 7'd1,  7'd2,  7'd3,  7'd4,  7'd5,
    7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,
    7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13,
    7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
    7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21,
    7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
    7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
    7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd1
  };

  localparam pos_t SEL_TAB [32] = '{
    7'd35, 7'd38, 7'd46, 7'd6,  7'd43, 7'd40, 7'd14, 7'd45,
    7'd33, 7'd19, 7'd26, 7'd15, 7'd23, 7'd8,  7'd22, 7'd10,
    7'd12, 7'd11, 7'd5,  7'd25, 7'd27, 7'd21, 7'd16, 7'd31,
    7'd28, 7'd32, 7'd34, 7'd24, 7'd9,  7'd37, 7'd2,  7'd1
  };

  localparam pos_t P_TAB [32] = '{
    7'd16, 7'd7,  7'd20, 7'd21, 7'd29, 7'd12, 7'd28, 7'd17,
    7'd1,  7'd15, 7'd23, 7'd26, 7'd5,  7'd18, 7'd31, 7'd10,
    7'd2,  7'd8,  7'd24, 7'd14, 7'd32, 7'd27, 7'd3,  7'd9,
    7'd19, 7'd13, 7'd30, 7'd6,  7'd22, 7'd11, 7'd4,  7'd25
  };

  localparam pos_t PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam pos_t PC2_TAB [48] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28,
    7'd15, 7'd6,  7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,
    7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40,
    7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
    7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
  };

  // running total of the per-round left rotations
  localparam shift_t ROT_TOTAL [ROUND_COUNT] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  function automatic logic [63:0] init_perm(input logic [63:0] src);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) begin
      res[6'(63 - i)] = src[6'(64 - int'(IP_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [63:0] final_perm(input logic [63:0] src);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) begin
      res[6'(63 - i)] = src[6'(64 - int'(FP_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [47:0] expand(input logic [31:0] src);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[6'(47 - i)] = src[5'(32 - int'(E_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [31:0] select_bits(input logic [47:0] src);
    logic [31:0] res;
    for (int i = 0; i < 32; i++) begin
      res[5'(31 - i)] = src[6'(48 - int'(SEL_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [31:0] pbox(input logic [31:0] src);
    logic [31:0] res;
    for (int i = 0; i < 32; i++) begin
      res[5'(31 - i)] = src[5'(32 - int'(P_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [55:0] pc1(input logic [63:0] src);
    logic [55:0] res;
    for (int i = 0; i < 56; i++) begin
      res[6'(55 - i)] = src[6'(64 - int'(PC1_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [47:0] pc2(input logic [55:0] src);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[6'(47 - i)] = src[6'(56 - int'(PC2_TAB[i]))];
    end
    return res;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] v, input shift_t n);
    logic [55:0] t;
    t = {v, v} << n;
    return t[55:28];
  endfunction

  function automatic logic [47:0] round_key(input logic [55:0] k56, input shift_t n);
    logic [27:0] c;
    logic [27:0] d;
    c = rotl28(k56[55:28], n);
    d = rotl28(k56[27:0], n);
    return pc2({c, d});
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] half, input logic [47:0] sk);
    return pbox(select_bits(expand(half) ^ sk));
  endfunction

endpackage

[rtl/fdv_req_if.sv]
// request channel carrying the command and the input block
interface fdv_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] block_in;

  modport source (output valid, output command, output block_in, input ready);
  modport sink (input valid, input command, input block_in, output ready);
endinterface

[rtl/fdv_rsp_if.sv]
// result channel carrying the output block
interface fdv_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;

  modport source (output valid, output block_out, input ready);
  modport sink (input valid, input block_out, output ready);
endinterface

[rtl/feistel_des_variant_cipher.sv]
// top level of the sixteen-round feistel cipher with a registered single pass
// The block takes one request per cycle when the result side does not stall
// and returns each result from its output register: the request is
// captured in an input register, all sixteen rounds, the key schedule and
// both permutations are evaluated as one combinational pass of wiring and
// XOR, and the block lands in an output register. Throughput is one block
// per cycle, set by the pair of registers acting as a two-entry pipeline;
// a stalled result holds the output register and the input register keeps
// one more request. The 64-bit key is written through cfg_we_i/cfg_wdata_i
// and must only change while no request is in flight; it resets to zero.
module feistel_des_variant_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  fdv_req_if.sink     req_i,
  fdv_rsp_if.source   rsp_o
);

  logic [63:0] key_q;
  logic        stg_valid_q;
  logic        stg_cmd_q;
  logic [63:0] stg_block_q;
  logic        out_valid_q;
  logic [63:0] out_block_q;

  logic        out_take;
  logic        in_take;
  logic [55:0] key56;
  logic [47:0] subkey [fdv_pkg::ROUND_COUNT];
  logic [31:0] lh [fdv_pkg::ROUND_COUNT + 1];
  logic [31:0] rh [fdv_pkg::ROUND_COUNT + 1];
  logic [63:0] perm_in;
  logic [63:0] result;

  assign out_take    = stg_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !stg_valid_q || out_take;
  assign in_take     = req_i.valid && req_i.ready;

  assign key56 = fdv_pkg::pc1(key_q);

  for (genvar g = 0; g < fdv_pkg::ROUND_COUNT; g++) begin : g_key
    assign subkey[g] = fdv_pkg::round_key(key56, fdv_pkg::ROT_TOTAL[g]);
  end

  assign perm_in = fdv_pkg::init_perm(stg_block_q);
  assign lh[0]   = perm_in[63:32];
  assign rh[0]   = perm_in[31:0];

  for (genvar g = 0; g < fdv_pkg::ROUND_COUNT; g++) begin : g_round
    logic [47:0] k;
    assign k         = stg_cmd_q ? subkey[fdv_pkg::ROUND_COUNT - 1 - g] : subkey[g];
    assign lh[g + 1] = rh[g];
    assign rh[g + 1] = lh[g] ^ fdv_pkg::round_fn(rh[g], k);
  end

  assign result = fdv_pkg::final_perm({rh[fdv_pkg::ROUND_COUNT], lh[fdv_pkg::ROUND_COUNT]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      if (req_i.ready) begin
        stg_valid_q <= req_i.valid;
      end
      if (out_take) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stg_cmd_q   <= req_i.command;
      stg_block_q <= req_i.block_in;
    end
    if (out_take) begin
      out_block_q <= result;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.block_out = out_block_q;

  // accepted request sits in the input register next cycle
  a_req_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> stg_valid_q)
    else $error("accepted request not staged");

  // a staged block moving on always shows up as a result
  a_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take |=> rsp_o.valid && rsp_o.block_out == $past(result))
    else $error("staged block lost on its way out");

  // both registers full and stalled means no new request
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q && out_valid_q && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while pipeline full");

endmodule
